/* sv/vmos_pkg.sv */
// Shared types and codes for the operand stack unit.
package vmos_pkg;

   localparam int unsigned DEPTH_W = 9;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned MODE_W  = 2;
   localparam int unsigned STAT_W  = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH = 2'd0,
      MODE_POP  = 2'd1,
      MODE_PEEK = 2'd2,
      MODE_SWAP = 2'd3
   } mode_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_UNDERFLOW = 2'd1,
      STAT_BAD_INDEX = 2'd2,
      STAT_FULL      = 2'd3
   } status_type;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic start;   // word accepted: run checks and issue the stack read
      logic finish;  // write back, update depth and top, load the result
   } cmd_type;

endpackage

/* sv/vm_operand_stack_unit_top.sv */
// Top level of the operand stack unit: stream ports, sequencer and datapath.
// Each word passes through an accept step, which issues the checks and the
// one-port stack memory read, then an execute step that writes back and loads
// the result. A new word is accepted only once the previous one has finished.
// Results sit in an output register; a stalled result holds the execute step.
// Synchronous active-high reset clears depth, handshake state and the limit
// (to 256); the entry memory is not cleared and needs no clearing pass.
module vm_operand_stack_unit_top #(
   parameter int unsigned NUM_ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   // Command words.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] immediate
   input  logic [1:0]  req_tuser,   // [1:0] mode
   // Result words.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [1:0] status, [10:2] depth, [42:11] top_value, rest zero
   // Stack limit register.
   input  logic        csr_wr_en,
   input  logic [8:0]  csr_wr_data
);

   vmos_pkg::cmd_type            cmd;
   logic [vmos_pkg::STAT_W-1:0]  status;
   logic [vmos_pkg::DEPTH_W-1:0] depth;
   logic [vmos_pkg::VALUE_W-1:0] top_value;

   // The sequencer only steps the handshake; all stack state is in the datapath.
   vmos_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   vmos_datapath #(
      .NUM_ENTRIES (NUM_ENTRIES)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_mode      (req_tuser),
      .req_immediate (req_tdata),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .rsp_status    (status),
      .rsp_depth     (depth),
      .rsp_top_value (top_value)
   );

   // Pack the result fields from the lowest bit up and pad to whole bytes.
   assign rsp_tdata = {5'b0, top_value, depth, status};

endmodule

/* sv/vmos_ctrl.sv */
// Sequencer of the operand stack unit: accept, execute and result handshake.
module vmos_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output vmos_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd.start    = 1'b0;
      cmd.finish   = 1'b0;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // Hold the finished word until the result register can take it.
            if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* sv/vmos_datapath.sv */
// Datapath of the operand stack unit: entry memory, top register, depth and checks.
module vmos_datapath #(
   parameter int unsigned NUM_ENTRIES = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  vmos_pkg::cmd_type               cmd,
   input  logic [vmos_pkg::MODE_W-1:0]     req_mode,
   input  logic [vmos_pkg::VALUE_W-1:0]    req_immediate,
   input  logic                            csr_wr_en,
   input  logic [vmos_pkg::DEPTH_W-1:0]    csr_wr_data,
   output logic [vmos_pkg::STAT_W-1:0]     rsp_status,
   output logic [vmos_pkg::DEPTH_W-1:0]    rsp_depth,
   output logic [vmos_pkg::VALUE_W-1:0]    rsp_top_value
);

   localparam int unsigned AW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
   localparam int unsigned CAP = (NUM_ENTRIES < 511) ? NUM_ENTRIES : 511;
   localparam logic [vmos_pkg::DEPTH_W-1:0] CAP_LIMIT = vmos_pkg::DEPTH_W'(CAP);
   localparam logic [vmos_pkg::DEPTH_W-1:0] LIMIT_RESET = vmos_pkg::DEPTH_W'(256);

   // The top entry lives in top_ff; mem holds the entries below it, bottom at 0.
   logic [vmos_pkg::VALUE_W-1:0] mem [NUM_ENTRIES];

   logic [vmos_pkg::DEPTH_W-1:0] limit_ff;
   logic [vmos_pkg::DEPTH_W-1:0] count_ff, count_in;
   logic [vmos_pkg::VALUE_W-1:0] top_ff, top_in;
   logic [vmos_pkg::VALUE_W-1:0] rd_data_ff;
   vmos_pkg::mode_type           mode_ff;
   vmos_pkg::status_type         status_ff, status_in;
   logic [vmos_pkg::VALUE_W-1:0] imm_ff;
   logic                         imm_zero_ff;

   logic [vmos_pkg::STAT_W-1:0]  rsp_status_ff;
   logic [vmos_pkg::DEPTH_W-1:0] rsp_depth_ff;
   logic [vmos_pkg::VALUE_W-1:0] rsp_top_ff;

   logic [vmos_pkg::DEPTH_W-1:0] lim;
   logic                         at_limit, over_limit, bad_index;
   logic [AW-1:0]                cnt_a, rd_addr, wr_addr;
   logic                         wr_en;
   vmos_pkg::mode_type           req_op;

   assign req_op     = vmos_pkg::mode_type'(req_mode);
   assign lim        = (limit_ff > CAP_LIMIT) ? CAP_LIMIT : limit_ff;
   assign at_limit   = (count_ff >= lim);
   assign over_limit = (count_ff > lim);
   assign bad_index  = (req_immediate >= vmos_pkg::VALUE_W'(count_ff));
   assign cnt_a      = AW'(count_ff);

   // Checks run on the accepted word against the depth before the operation.
   always_comb begin
      status_in = vmos_pkg::STAT_OK;
      rd_addr   = cnt_a - AW'(2);
      unique case (req_op)
         vmos_pkg::MODE_PUSH: begin
            if (at_limit) status_in = vmos_pkg::STAT_FULL;
         end
         vmos_pkg::MODE_POP: begin
            if (count_ff == '0) status_in = vmos_pkg::STAT_UNDERFLOW;
         end
         vmos_pkg::MODE_PEEK: begin
            rd_addr = cnt_a - AW'(1) - AW'(req_immediate);
            if (bad_index)     status_in = vmos_pkg::STAT_BAD_INDEX;
            else if (at_limit) status_in = vmos_pkg::STAT_FULL;
         end
         vmos_pkg::MODE_SWAP: begin
            if (count_ff < vmos_pkg::DEPTH_W'(2)) status_in = vmos_pkg::STAT_UNDERFLOW;
            else if (over_limit)                  status_in = vmos_pkg::STAT_FULL;
         end
         default: ;
      endcase
   end

   // Write-back, new top and new depth once the read data is in.
   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = cnt_a - AW'(1);
      top_in   = top_ff;
      count_in = count_ff;
      if (status_ff == vmos_pkg::STAT_OK) begin
         unique case (mode_ff)
            vmos_pkg::MODE_PUSH: begin
               wr_en    = (count_ff != '0);
               top_in   = imm_ff;
               count_in = count_ff + vmos_pkg::DEPTH_W'(1);
            end
            vmos_pkg::MODE_POP: begin
               top_in   = rd_data_ff;
               count_in = count_ff - vmos_pkg::DEPTH_W'(1);
            end
            vmos_pkg::MODE_PEEK: begin
               wr_en    = 1'b1;
               top_in   = imm_zero_ff ? top_ff : rd_data_ff;
               count_in = count_ff + vmos_pkg::DEPTH_W'(1);
            end
            vmos_pkg::MODE_SWAP: begin
               wr_en   = 1'b1;
               wr_addr = cnt_a - AW'(2);
               top_in  = rd_data_ff;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (cmd.finish && wr_en) begin
         mem[wr_addr] <= top_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
         count_ff <= '0;
      end else begin
         if (csr_wr_en) limit_ff <= csr_wr_data;
         if (cmd.finish) count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         mode_ff     <= req_op;
         imm_ff      <= req_immediate;
         imm_zero_ff <= (req_immediate == '0);
         status_ff   <= status_in;
      end
      if (cmd.finish) begin
         top_ff        <= top_in;
         rsp_status_ff <= status_ff;
         rsp_depth_ff  <= count_in;
         rsp_top_ff    <= (count_in == '0) ? '0 : top_in;
      end
   end

   assign rsp_status    = rsp_status_ff;
   assign rsp_depth     = rsp_depth_ff;
   assign rsp_top_value = rsp_top_ff;

endmodule

/* dv/tb_vm_operand_stack_unit_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the operand stack unit: directed and random stack bytecodes.
module tb_vm_operand_stack_unit_top;

   // Entry count of the instance under test, which uses the default depth.
   localparam int unsigned STACK_ENTRIES = 256;
   localparam int unsigned LIMIT_RESET   = 256;

   // One expected result word, with the fields at the widths of the port.
   typedef struct {
      vmos_pkg::status_type                 status;
      logic [vmos_pkg::DEPTH_W-1:0]         depth;
      logic [vmos_pkg::VALUE_W-1:0]         top_value;
   } stack_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic        csr_wr_en;
   logic [8:0]  csr_wr_data;

   // Our own copy of the stack, its depth and the limit register.
   logic [vmos_pkg::VALUE_W-1:0] shadow_stack [STACK_ENTRIES];
   int unsigned                  shadow_count;
   logic [8:0]                   shadow_limit;

   // Results predicted for accepted command words, oldest first.
   stack_result_type pending_results [$];

   int unsigned mismatch_count;

   // Idling switches: when set, each side draws a random wait before each word.
   bit req_idle_on;
   bit rsp_idle_on;

   vm_operand_stack_unit_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // A hard stop well past the slowest correct run.
   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: mismatch in %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
      mismatch_count++;
   endtask

   // Applies one bytecode to the shadow stack and queues the result it must give.
   // The peek range check comes before the full check, and swap is refused
   // when a lowered limit sits below the current depth.
   task automatic apply_stack_op(input vmos_pkg::mode_type mode, input logic [31:0] imm);
      stack_result_type res;
      int unsigned      cap;
      logic [31:0]      held;
      cap = (32'(shadow_limit) > STACK_ENTRIES) ? STACK_ENTRIES : 32'(shadow_limit);
      res.status = vmos_pkg::STAT_OK;
      case (mode)
         vmos_pkg::MODE_PUSH: begin
            if (shadow_count + 1 > cap) begin
               res.status = vmos_pkg::STAT_FULL;
            end else begin
               shadow_stack[shadow_count] = imm;
               shadow_count++;
            end
         end
         vmos_pkg::MODE_POP: begin
            if (shadow_count < 1) res.status = vmos_pkg::STAT_UNDERFLOW;
            else shadow_count--;
         end
         vmos_pkg::MODE_PEEK: begin
            if (imm >= shadow_count) begin
               res.status = vmos_pkg::STAT_BAD_INDEX;
            end else if (shadow_count + 1 > cap) begin
               res.status = vmos_pkg::STAT_FULL;
            end else begin
               shadow_stack[shadow_count] = shadow_stack[shadow_count - imm - 1];
               shadow_count++;
            end
         end
         default: begin
            if (shadow_count < 2) begin
               res.status = vmos_pkg::STAT_UNDERFLOW;
            end else if (shadow_count > cap) begin
               res.status = vmos_pkg::STAT_FULL;
            end else begin
               held = shadow_stack[shadow_count - 1];
               shadow_stack[shadow_count - 1] = shadow_stack[shadow_count - 2];
               shadow_stack[shadow_count - 2] = held;
            end
         end
      endcase
      res.depth     = shadow_count[vmos_pkg::DEPTH_W-1:0];
      res.top_value = (shadow_count != 0) ? shadow_stack[shadow_count - 1] : '0;
      pending_results.push_back(res);
   endtask

   // Sends one command word. Called and left at a falling edge; valid stays
   // high after the accept so that a back-to-back word keeps it up.
   task automatic send_word(input vmos_pkg::mode_type mode, input logic [31:0] imm);
      int unsigned gap;
      gap = req_idle_on ? $urandom_range(0, 18) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= imm;
      req_tuser  <= mode;
      do @(posedge clock); while (!req_tready);
      apply_stack_op(mode, imm);
      @(negedge clock);
   endtask

   // Stops sending and waits until every predicted result has come back.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Writes the limit register while the unit is idle.
   task automatic write_limit(input logic [8:0] value);
      wait_for_drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      shadow_limit = value;
      @(negedge clock);
   endtask

   task automatic clear_stack();
      while (shadow_count != 0) send_word(vmos_pkg::MODE_POP, $urandom);
   endtask

   // Every check on an empty stack: pop, swap and peek are all refused.
   task automatic test_empty_stack();
      send_word(vmos_pkg::MODE_POP, 32'h0);
      send_word(vmos_pkg::MODE_SWAP, 32'hFFFF_FFFF);
      send_word(vmos_pkg::MODE_PEEK, 32'h0);
   endtask

   // Each operation with extreme immediates, plus the range and underflow cases.
   task automatic test_basic_ops();
      send_word(vmos_pkg::MODE_PUSH, 32'h0000_0000);
      send_word(vmos_pkg::MODE_PUSH, 32'hFFFF_FFFF);
      send_word(vmos_pkg::MODE_SWAP, 32'h0);
      send_word(vmos_pkg::MODE_PEEK, 32'h1);
      send_word(vmos_pkg::MODE_PEEK, 32'h3);          // index equal to the depth
      send_word(vmos_pkg::MODE_PEEK, 32'hFFFF_FFFF);  // index far beyond the depth
      send_word(vmos_pkg::MODE_POP, 32'h0);
      send_word(vmos_pkg::MODE_POP, 32'h0);
      send_word(vmos_pkg::MODE_SWAP, 32'h0);          // a single entry cannot be swapped
      send_word(vmos_pkg::MODE_POP, 32'h0);
   endtask

   // Limit at zero, limit reached, and a limit lowered below the held depth.
   task automatic test_limit_edges();
      clear_stack();
      write_limit(9'd0);
      send_word(vmos_pkg::MODE_PUSH, 32'h1234_5678);
      send_word(vmos_pkg::MODE_PEEK, 32'h0);          // range check wins over the full check
      write_limit(9'd3);
      send_word(vmos_pkg::MODE_PUSH, 32'hAAAA_AAAA);
      send_word(vmos_pkg::MODE_PUSH, 32'h5555_5555);
      send_word(vmos_pkg::MODE_PUSH, 32'h8000_0001);
      send_word(vmos_pkg::MODE_PUSH, 32'h7FFF_FFFE);
      send_word(vmos_pkg::MODE_PEEK, 32'h0);
      send_word(vmos_pkg::MODE_SWAP, 32'h0);
      write_limit(9'd1);
      send_word(vmos_pkg::MODE_SWAP, 32'h0);          // depth above the lowered limit
      send_word(vmos_pkg::MODE_PUSH, 32'h0);
      send_word(vmos_pkg::MODE_POP, 32'h0);
      write_limit(9'd511);
      send_word(vmos_pkg::MODE_PUSH, 32'hFFFF_0000);
   endtask

   // Fills the whole stack with random content, then probes the full case.
   task automatic test_fill_to_capacity();
      write_limit(9'd256);
      while (shadow_count < STACK_ENTRIES) begin
         // Half the fill runs without gaps on either side.
         req_idle_on = (shadow_count >= STACK_ENTRIES / 2);
         rsp_idle_on = (shadow_count >= STACK_ENTRIES / 2);
         send_word(vmos_pkg::MODE_PUSH, $urandom);
      end
      send_word(vmos_pkg::MODE_PUSH, $urandom);
      send_word(vmos_pkg::MODE_PEEK, 32'h0);
      send_word(vmos_pkg::MODE_PEEK, STACK_ENTRIES);  // bad index even when full
      send_word(vmos_pkg::MODE_PEEK, STACK_ENTRIES - 1);
      send_word(vmos_pkg::MODE_SWAP, $urandom);
      repeat (20) begin
         if ($urandom_range(0, 3) == 0) send_word(vmos_pkg::MODE_SWAP, $urandom);
         else send_word(vmos_pkg::MODE_POP, $urandom);
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   function automatic logic [31:0] pick_peek_index();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 8 && shadow_count != 0) return $urandom_range(0, shadow_count - 1);
      if (pick == 8) return shadow_count;
      return $urandom;
   endfunction

   // Random bytecodes in segments, each with its own limit, direction and idling.
   task automatic test_random_mix();
      int unsigned grow;
      int unsigned roll;
      logic [8:0]  lim;
      logic [31:0] imm;
      for (int seg = 0; seg < 5; seg++) begin
         case ($urandom_range(0, 5))
            0:       lim = 9'd0;
            1:       lim = 9'd1;
            2:       lim = 9'd2;
            3:       lim = 9'd256;
            4:       lim = 9'd511;
            default: lim = 9'($urandom_range(0, 40));
         endcase
         write_limit(lim);
         grow        = $urandom_range(0, 2);
         req_idle_on = $urandom_range(0, 2) != 0;
         rsp_idle_on = $urandom_range(0, 2) != 0;
         for (int n = 0; n < 50; n++) begin
            // Once per segment the sender holds off until all results are back.
            if (n == 25) wait_for_drain();
            roll = $urandom_range(0, 99);
            case ($urandom_range(0, 2))
               0:       imm = $urandom;
               1:       imm = 32'hFFFF_FFFF;
               default: imm = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            endcase
            if (roll < (grow == 0 ? 20 : grow == 1 ? 40 : 60))
               send_word(vmos_pkg::MODE_PUSH, imm);
            else if (roll < 70)
               send_word(vmos_pkg::MODE_PEEK, pick_peek_index());
            else if (roll < 85)
               send_word(vmos_pkg::MODE_POP, imm);
            else
               send_word(vmos_pkg::MODE_SWAP, imm);
         end
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   // Result side: draws a stall per word, then compares each accepted word
   // field by field with the oldest prediction.
   initial begin
      int unsigned      stall;
      stack_result_type want;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = rsp_idle_on ? $urandom_range(0, 18) : 0;
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result word, depth", 32'(rsp_tdata[10:2]), 32'h0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[1:0] !== want.status)
               report_mismatch("status", 32'(rsp_tdata[1:0]), 32'(want.status));
            if (rsp_tdata[10:2] !== want.depth)
               report_mismatch("depth", 32'(rsp_tdata[10:2]), 32'(want.depth));
            if (rsp_tdata[42:11] !== want.top_value)
               report_mismatch("top_value", rsp_tdata[42:11], want.top_value);
            if (rsp_tdata[47:43] !== 5'b0)
               report_mismatch("padding", 32'(rsp_tdata[47:43]), 32'h0);
         end
         @(negedge clock);
      end
   end

   // Main sequence: reset once, run each test in turn, then drain and judge.
   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = '0;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      shadow_count = 0;
      shadow_limit = 9'(LIMIT_RESET);
      mismatch_count = 0;
      req_idle_on  = 1'b1;
      rsp_idle_on  = 1'b1;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_stack();
      test_basic_ops();
      test_limit_edges();
      test_fill_to_capacity();
      test_random_mix();

      wait_for_drain();
      repeat (10) @(negedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
